// ===== rtl/bhv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bearing homing velocity package
// Fixed-point constants, reciprocal multipliers and shared arithmetic helpers.
// ---------------------------------------------------------------------------
package bhv_pkg;

    localparam int SC_LAT = 10;

    localparam logic signed [17:0] ANG_PI      = 18'sd12868;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd25736;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd6434;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int RCP_SHIFT = 39;
    localparam logic [38:0] RCP_72 = 39'(((64'd1 << RCP_SHIFT) + 64'd71) / 64'd72);
    localparam logic [38:0] RCP_42 = 39'(((64'd1 << RCP_SHIFT) + 64'd41) / 64'd42);
    localparam logic [38:0] RCP_20 = 39'(((64'd1 << RCP_SHIFT) + 64'd19) / 64'd20);
    localparam logic [38:0] RCP_6  = 39'(((64'd1 << RCP_SHIFT) + 64'd5) / 64'd6);
    localparam logic [38:0] RCP_90 = 39'(((64'd1 << RCP_SHIFT) + 64'd89) / 64'd90);
    localparam logic [38:0] RCP_56 = 39'(((64'd1 << RCP_SHIFT) + 64'd55) / 64'd56);
    localparam logic [38:0] RCP_30 = 39'(((64'd1 << RCP_SHIFT) + 64'd29) / 64'd30);
    localparam logic [38:0] RCP_12 = 39'(((64'd1 << RCP_SHIFT) + 64'd11) / 64'd12);

    localparam logic [15:0] GAIN_RESET = 16'd768;

    localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [15:0] e21;
        logic signed [15:0] e32;
        logic signed [15:0] e13;
        logic [3:0]         neg;
    } bhv_tag_t;

    // exact floor(v / d) for v < 2^32 via reciprocal multiply
    function automatic logic [31:0] div_rcp(input logic [31:0] v, input logic [38:0] m);
        logic [70:0] p;
        p = 71'(v) * 71'(m);
        return p[70:39];
    endfunction

    // unsigned Q30 product
    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [30:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[61:30];
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] p,
                                                   input int unsigned k);
        logic signed [63:0] bias;
        bias = (64'sd1 <<< k) - 64'sd1;
        return (p + ((p < 0) ? bias : 64'sd0)) >>> k;
    endfunction

    // wrap to (-pi, pi]
    function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        for (int i = 0; i < 3; i++) begin
            if (r > ANG_PI)
            begin
                r = r - ANG_TWO_PI;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r <= -ANG_PI)
            begin
                r = r + ANG_TWO_PI;
            end
        end
        return r[15:0];
    endfunction

endpackage

// ===== rtl/bhv_sincos.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sine and cosine pipeline
// Horner-form series in Q30, one multiply or one reciprocal divide per stage but the last.
// ---------------------------------------------------------------------------
module bhv_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] x,
    output logic signed [31:0] s,
    output logic signed [31:0] c
);
    import bhv_pkg::*;

    logic signed [63:0] xx;
    logic signed [63:0] xs;
    logic signed [31:0] xd_reg [8];
    logic [31:0]        x2_reg [8];
    logic [30:0]        ts2_reg, tc2_reg, ts4_reg, tc4_reg, ts6_reg, tc6_reg, ts8_reg, tc8_reg;
    logic [31:0]        ps3_reg, pc3_reg, ps5_reg, pc5_reg, ps7_reg, pc7_reg, pc9_reg;
    logic signed [31:0] s9_reg, s10_reg, c10_reg;

    assign xx = 64'(x) * 64'(x);
    assign xs = 64'(xd_reg[7]) * 64'(signed'({1'b0, ts8_reg}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= x;
            x2_reg[0] <= xx[61:30];
            for (int i = 1; i < 8; i++) begin
                xd_reg[i] <= xd_reg[i-1];
                x2_reg[i] <= x2_reg[i-1];
            end
            ts2_reg <= Q30_ONE - 31'(div_rcp(x2_reg[0], RCP_72));
            tc2_reg <= Q30_ONE - 31'(div_rcp(x2_reg[0], RCP_90));
            ps3_reg <= mul_q30(x2_reg[1], ts2_reg);
            pc3_reg <= mul_q30(x2_reg[1], tc2_reg);
            ts4_reg <= Q30_ONE - 31'(div_rcp(ps3_reg, RCP_42));
            tc4_reg <= Q30_ONE - 31'(div_rcp(pc3_reg, RCP_56));
            ps5_reg <= mul_q30(x2_reg[3], ts4_reg);
            pc5_reg <= mul_q30(x2_reg[3], tc4_reg);
            ts6_reg <= Q30_ONE - 31'(div_rcp(ps5_reg, RCP_20));
            tc6_reg <= Q30_ONE - 31'(div_rcp(pc5_reg, RCP_30));
            ps7_reg <= mul_q30(x2_reg[5], ts6_reg);
            pc7_reg <= mul_q30(x2_reg[5], tc6_reg);
            ts8_reg <= Q30_ONE - 31'(div_rcp(ps7_reg, RCP_6));
            tc8_reg <= Q30_ONE - 31'(div_rcp(pc7_reg, RCP_12));
            s9_reg  <= 32'(sdiv_p2(xs, 30));
            pc9_reg <= mul_q30(x2_reg[7], tc8_reg);
            s10_reg <= s9_reg;
            c10_reg <= signed'({1'b0, Q30_ONE}) - signed'({1'b0, pc9_reg[31:1]});
        end
    end

    assign s = s10_reg;
    assign c = c10_reg;

endmodule

// ===== rtl/bearing_homing_velocity.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bearing homing velocity
// Landmark bearing homing: weighted landmark vectors, heading rotation, gain.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and not taken. The 10-stage series sine/cosine unit
// sets most of the depth. Reset clears all valid bits and loads gain 3.0.
module bearing_homing_velocity (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // bearing_one, bearing_two, bearing_three, goal_bearing_one,
    // goal_bearing_two, goal_bearing_three, heading
    input  logic [111:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // vel_x, vel_y
    output logic [63:0]   m_tdata,
    // saturated
    output logic          m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import bhv_pkg::*;

    logic en;
    logic [15:0] gain_reg;

    logic signed [15:0] fb [7];
    logic signed [15:0] d21, d32, d13, h21, h32, h13;
    logic signed [15:0] wa [4];
    logic signed [15:0] fa [4];
    logic [3:0]         ng;
    logic signed [31:0] xa_next [7];
    bhv_tag_t           taga_next;

    logic signed [31:0] xa_reg [7];
    bhv_tag_t           taga_reg;
    logic               va_reg;
    bhv_tag_t           tag_reg [SC_LAT];
    logic [SC_LAT-1:0]  vd_reg;
    logic signed [31:0] sn [7];
    logic signed [31:0] cs [7];

    logic signed [15:0] ed [3];
    logic signed [20:0] w_reg [3];
    logic signed [31:0] cw_reg [4], sw_reg [4];
    logic               vw_reg;
    logic signed [21:0] k_reg [3];
    logic signed [31:0] ck_reg [4], sk_reg [4];
    logic               vk_reg;
    logic signed [53:0] kc_reg [3], ks_reg [3];
    logic signed [31:0] shp_reg, chp_reg;
    logic               vp_reg;
    logic signed [23:0] sx_reg, sy_reg;
    logic signed [31:0] shs_reg, chs_reg;
    logic               vs_reg;
    logic signed [55:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic               vr_reg;
    logic signed [25:0] rx_reg, ry_reg;
    logic               vr2_reg;
    logic signed [63:0] gx, gy, qx, qy;
    logic signed [31:0] ox_reg, oy_reg;
    logic               sat_reg;
    logic               vo_reg;

    assign en        = !vo_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 7; i++) begin
            fb[i] = signed'(s_tdata[16*i +: 16]);
        end
        d21 = wrap_ang(18'(fb[1]) - 18'(fb[0]));
        d32 = wrap_ang(18'(fb[2]) - 18'(fb[1]));
        d13 = wrap_ang(18'(fb[0]) - 18'(fb[2]));
        h21 = wrap_ang(18'(fb[4]) - 18'(fb[3]));
        h32 = wrap_ang(18'(fb[5]) - 18'(fb[4]));
        h13 = wrap_ang(18'(fb[3]) - 18'(fb[5]));
        wa[0] = wrap_ang(18'(fb[0]));
        wa[1] = wrap_ang(18'(fb[1]));
        wa[2] = wrap_ang(18'(fb[2]));
        wa[3] = wrap_ang(18'(fb[6]));
        for (int j = 0; j < 4; j++) begin
            if (18'(wa[j]) > ANG_HALF_PI)
            begin
                fa[j] = 16'(ANG_PI - 18'(wa[j]));
                ng[j] = 1'b1;
            end
            else if (18'(wa[j]) < -ANG_HALF_PI)
            begin
                fa[j] = 16'(-ANG_PI - 18'(wa[j]));
                ng[j] = 1'b1;
            end
            else
            begin
                fa[j] = wa[j];
                ng[j] = 1'b0;
            end
        end
        xa_next[0] = 32'(d21) <<< 17;
        xa_next[1] = 32'(d32) <<< 17;
        xa_next[2] = 32'(d13) <<< 17;
        for (int j = 0; j < 4; j++) begin
            xa_next[3+j] = 32'(fa[j]) <<< 18;
        end
        taga_next.e21 = d21 - h21;
        taga_next.e32 = d32 - h32;
        taga_next.e13 = d13 - h13;
        taga_next.neg = ng;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vd_reg  <= '0;
            vw_reg  <= 1'b0;
            vk_reg  <= 1'b0;
            vp_reg  <= 1'b0;
            vs_reg  <= 1'b0;
            vr_reg  <= 1'b0;
            vr2_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            va_reg  <= s_tvalid;
            vd_reg  <= {vd_reg[SC_LAT-2:0], va_reg};
            vw_reg  <= vd_reg[SC_LAT-1];
            vk_reg  <= vw_reg;
            vp_reg  <= vk_reg;
            vs_reg  <= vp_reg;
            vr_reg  <= vs_reg;
            vr2_reg <= vr_reg;
            vo_reg  <= vr2_reg;
        end
    end

    for (genvar g = 0; g < 7; g++) begin : g_sc
        bhv_sincos u_sc (
            .clk (clk),
            .en  (en),
            .x   (xa_reg[g]),
            .s   (sn[g]),
            .c   (cs[g])
        );
    end

    assign ed[0] = tag_reg[SC_LAT-1].e21;
    assign ed[1] = tag_reg[SC_LAT-1].e32;
    assign ed[2] = tag_reg[SC_LAT-1].e13;

    assign gx = 64'(rx_reg) * 64'(signed'({1'b0, gain_reg}));
    assign gy = 64'(ry_reg) * 64'(signed'({1'b0, gain_reg}));
    assign qx = sdiv_p2(gx, 8);
    assign qy = sdiv_p2(gy, 8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg     <= xa_next;
            taga_reg   <= taga_next;
            tag_reg[0] <= taga_reg;
            for (int i = 1; i < SC_LAT; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end

            for (int i = 0; i < 3; i++) begin
                w_reg[i] <= 21'(sdiv_p2(64'(cs[i]) * 64'(ed[i]), 25));
            end
            for (int j = 0; j < 4; j++) begin
                cw_reg[j] <= tag_reg[SC_LAT-1].neg[j] ? -cs[3+j] : cs[3+j];
                sw_reg[j] <= sn[3+j];
            end

            k_reg[0] <= 22'(w_reg[2]) + 22'(w_reg[0]);
            k_reg[1] <= 22'(w_reg[0]) + 22'(w_reg[1]);
            k_reg[2] <= 22'(w_reg[1]) + 22'(w_reg[2]);
            ck_reg   <= cw_reg;
            sk_reg   <= sw_reg;

            for (int i = 0; i < 3; i++) begin
                kc_reg[i] <= 54'(k_reg[i]) * 54'(ck_reg[i]);
                ks_reg[i] <= 54'(k_reg[i]) * 54'(sk_reg[i]);
            end
            shp_reg <= sk_reg[3];
            chp_reg <= ck_reg[3];

            sx_reg  <= 24'(sdiv_p2(64'(kc_reg[0]) + 64'(kc_reg[1]) + 64'(kc_reg[2]), 30));
            sy_reg  <= 24'(sdiv_p2(64'(ks_reg[0]) + 64'(ks_reg[1]) + 64'(ks_reg[2]), 30));
            shs_reg <= shp_reg;
            chs_reg <= chp_reg;

            ra_reg <= 56'(sx_reg) * 56'(shs_reg);
            rb_reg <= 56'(sy_reg) * 56'(chs_reg);
            rc_reg <= 56'(sx_reg) * 56'(chs_reg);
            rd_reg <= 56'(sy_reg) * 56'(shs_reg);

            rx_reg <= 26'(sdiv_p2(64'(rb_reg) - 64'(ra_reg), 30));
            ry_reg <= 26'(sdiv_p2(64'(rc_reg) + 64'(rd_reg), 30));

            ox_reg  <= (qx > OUT_MAX) ? OUT_MAX[31:0] : ((qx < OUT_MIN) ? OUT_MIN[31:0] : qx[31:0]);
            oy_reg  <= (qy > OUT_MAX) ? OUT_MAX[31:0] : ((qy < OUT_MIN) ? OUT_MIN[31:0] : qy[31:0]);
            sat_reg <= (qx > OUT_MAX) || (qx < OUT_MIN) || (qy > OUT_MAX) || (qy < OUT_MIN);
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tuser  = sat_reg;

`ifndef SYNTHESIS
    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (ox_reg == 32'h7fff_ffff || ox_reg == 32'h8000_0000 ||
             oy_reg == 32'h7fff_ffff || oy_reg == 32'h8000_0000))
        else $error("saturated flag without a clipped component");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg[SC_LAT-1] |->
            (cs[3] <= 32'sh4000_0000 && cs[3] >= -32'sh4000_0000))
        else $error("series cosine out of unit range");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bearing homing velocity testbench
// Drives bearing sets through the stream port under several gain settings and
// idle patterns, predicts each velocity command in fixed point and compares.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int WATCH_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [31:0] PI_Q12 = 12868;
    localparam logic signed [31:0] TWO_PI_Q12 = 25736;
    localparam logic signed [31:0] HALF_PI_Q12 = 6434;
    localparam longint Q30 = 64'sd1073741824;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] goal3;
        logic signed [15:0] goal2;
        logic signed [15:0] goal1;
        logic signed [15:0] brg3;
        logic signed [15:0] brg2;
        logic signed [15:0] brg1;
    } bearing_set_t;

    typedef struct {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               sat;
    } velocity_cmd_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;
    logic          m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [15:0]   cfg_data = '0;

    velocity_cmd_t pending_cmds[$];
    logic [15:0]   gain_model;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            error_count = 0;
    int            quiet_cycles = 0;

    bearing_homing_velocity dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint wrap_q12(longint a);
        while (a > PI_Q12) a -= TWO_PI_Q12;
        while (a <= -PI_Q12) a += TWO_PI_Q12;
        return a;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b) / Q30;
    endfunction

    function automatic void taylor_sin_cos(longint x, output longint s, output longint c);
        longint x2;
        longint t;
        x2 = q30_mul(x, x);
        t = Q30 - x2 / 72;
        t = Q30 - q30_mul(x2, t) / 42;
        t = Q30 - q30_mul(x2, t) / 20;
        t = Q30 - q30_mul(x2, t) / 6;
        s = q30_mul(x, t);
        t = Q30 - x2 / 90;
        t = Q30 - q30_mul(x2, t) / 56;
        t = Q30 - q30_mul(x2, t) / 30;
        t = Q30 - q30_mul(x2, t) / 12;
        c = Q30 - q30_mul(x2, t) / 2;
    endfunction

    function automatic void angle_sin_cos(longint a, output longint s, output longint c);
        bit flip;
        flip = 1'b0;
        a = wrap_q12(a);
        if (a > HALF_PI_Q12)
        begin
            a = PI_Q12 - a;
            flip = 1'b1;
        end
        else if (a < -HALF_PI_Q12)
        begin
            a = -PI_Q12 - a;
            flip = 1'b1;
        end
        taylor_sin_cos(a * 262144, s, c);
        if (flip) c = -c;
    endfunction

    function automatic longint pair_weight_q16(longint d, longint dh);
        longint s;
        longint c;
        taylor_sin_cos(d * 131072, s, c);
        return (2 * c * (d - dh)) / (64'sd1 << 26);
    endfunction

    function automatic longint clamp_s32(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic velocity_cmd_t homing_velocity(bearing_set_t b, logic [15:0] gain);
        longint b1, b2, b3, g1, g2, g3;
        longint w21, w32, w13, k1, k2, k3;
        longint s1, c1, s2, c2, s3, c3, sh, ch;
        longint sx, sy, rx, ry;
        bit sat;
        velocity_cmd_t r;
        sat = 1'b0;
        b1 = b.brg1; b2 = b.brg2; b3 = b.brg3;
        g1 = b.goal1; g2 = b.goal2; g3 = b.goal3;
        w21 = pair_weight_q16(wrap_q12(b2 - b1), wrap_q12(g2 - g1));
        w32 = pair_weight_q16(wrap_q12(b3 - b2), wrap_q12(g3 - g2));
        w13 = pair_weight_q16(wrap_q12(b1 - b3), wrap_q12(g1 - g3));
        k1 = w13 + w21;
        k2 = w21 + w32;
        k3 = w32 + w13;
        angle_sin_cos(b1, s1, c1);
        angle_sin_cos(b2, s2, c2);
        angle_sin_cos(b3, s3, c3);
        sx = (k1 * c1 + k2 * c2 + k3 * c3) / Q30;
        sy = (k1 * s1 + k2 * s2 + k3 * s3) / Q30;
        angle_sin_cos(longint'(b.heading), sh, ch);
        rx = (-sx * sh + sy * ch) / Q30;
        ry = (sx * ch + sy * sh) / Q30;
        r.vel_x = 32'(clamp_s32((rx * longint'(gain)) / 256, sat));
        r.vel_y = 32'(clamp_s32((ry * longint'(gain)) / 256, sat));
        r.sat = sat;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("bearing_homing_velocity regression: fail");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        velocity_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected result vel_x=%0d vel_y=%0d", $signed(m_tdata[31:0]),
                       $signed(m_tdata[63:32]));
                error_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (m_tdata[31:0] !== want.vel_x)
                begin
                    $error("vel_x expected %0d actual %0d", want.vel_x, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[63:32] !== want.vel_y)
                begin
                    $error("vel_y expected %0d actual %0d", want.vel_y, $signed(m_tdata[63:32]));
                    error_count++;
                end
                if (m_tuser !== want.sat)
                begin
                    $error("saturated expected %0d actual %0d", want.sat, m_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic send_bearings(bearing_set_t b);
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        pending_cmds.push_back(homing_velocity(b, gain_model));
    endtask

    task automatic release_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        release_stream();
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(logic [15:0] g);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= g;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gain_model = g;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(25736)) - 12868);
            2: return 16'($signed($urandom_range(800)) - 400);
            default: return 16'($signed($urandom_range(2000)) - 1000 + 12868);
        endcase
    endfunction

    function automatic bearing_set_t rand_set();
        bearing_set_t b;
        b.brg1 = rand_angle(); b.brg2 = rand_angle(); b.brg3 = rand_angle();
        b.goal1 = rand_angle(); b.goal2 = rand_angle(); b.goal3 = rand_angle();
        b.heading = rand_angle();
        if ($urandom_range(3) == 0)
        begin
            b.goal1 = b.brg1 + 16'($signed($urandom_range(64)) - 32);
            b.goal2 = b.brg2 + 16'($signed($urandom_range(64)) - 32);
            b.goal3 = b.brg3 + 16'($signed($urandom_range(64)) - 32);
        end
        return b;
    endfunction

    task automatic test_directed();
        bearing_set_t b;
        logic signed [15:0] edges[8] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1,
                                         16'sd12868, -16'sd12868, 16'sd6434, -16'sd6435};
        foreach (edges[i])
        begin
            b = '{edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8], edges[(i + 1) % 8],
                  edges[(i + 6) % 8], edges[(i + 2) % 8], edges[(i + 4) % 8]};
            send_bearings(b);
        end
        send_bearings('0);
        send_bearings('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        send_bearings('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        send_bearings('{16'sd300, -16'sd12868, 16'sd12868, 16'sd0, 16'sd4000, -16'sd4000, 16'sd100});
        send_bearings('{16'sd0, 16'sd8000, -16'sd8000, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0});
    endtask

    task automatic test_saturation();
        write_gain(16'hffff);
        repeat (12)
        begin
            send_bearings('{16'($urandom), 16'sd32767, -16'sd32768, 16'($urandom),
                            -16'sd32768, 16'sd32767, 16'($urandom)});
        end
        repeat (40) send_bearings(rand_set());
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_bearings(rand_set());
    endtask

    task automatic test_gain_settings();
        logic [15:0] gains[4] = '{16'd0, 16'd1, 16'd256, 16'd768};
        foreach (gains[i])
        begin
            write_gain(gains[i]);
            test_random_phase(38, 38, 60);
        end
        write_gain(16'($urandom));
    endtask

    task automatic test_pause_until_empty();
        test_random_phase(0, 48, 30);
        release_stream();
        while (pending_cmds.size() != 0) @(posedge clk);
        test_random_phase(0, 0, 30);
    endtask

    initial
    begin
        gain_model = 16'd768;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_gain_settings();
        test_random_phase(0, 0, 450);
        test_random_phase(48, 0, 450);
        test_random_phase(0, 48, 450);
        test_random_phase(38, 38, 300);
        test_pause_until_empty();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        if (error_count == 0)
            $display("bearing_homing_velocity regression: pass");
        else
            $display("bearing_homing_velocity regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bhv_pkg.sv
rtl/bhv_sincos.sv
rtl/bearing_homing_velocity.sv
tb/tb_top.sv
